[hw/rtl/pid_mix_pkg.sv]
`default_nettype none
// Shared types, widths and register codes for the PID thruster mixer.
// Used by pid_mix_axis, pid_mix_out and pid_thruster_mixer_unit.

package pid_mix_pkg;

    localparam int DATA_W    = 20;
    localparam int FRAC_BITS = 12;
    localparam int SUM_W     = DATA_W + 8;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int GAIN_W    = 16;
    localparam int PV_W      = GAIN_W + DATA_W;
    localparam int PD_W      = GAIN_W + DIFF_W;
    localparam int PS_W      = GAIN_W + SUM_W;
    localparam int TERM_W    = GAIN_W + SUM_W + 2;
    localparam int MIX_W     = TERM_W + 2;
    localparam int RND_SHIFT = 8;
    localparam int NUM_AXES  = 4;
    localparam int AXIS_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int THRESH_W  = 19;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(41);

    // axis order, also the gain register order
    localparam int AX_SURGE = 0;
    localparam int AX_HEAVE = 1;
    localparam int AX_YAW   = 2;
    localparam int AX_PITCH = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SURGE  = 3'd0,
        REG_HEAVE  = 3'd1,
        REG_YAW    = 3'd2,
        REG_PITCH  = 3'd3,
        REG_SETTLE = 3'd4
    } reg_idx_t;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [MIX_W-1:0]  mix_t;

    typedef struct packed {
        data_t pos_x;
        data_t pos_y;
        data_t pos_z;
        data_t roll;
        data_t pitch;
        data_t yaw;
    } in_item_t;

    typedef struct packed {
        data_t thrust_0;
        data_t thrust_1;
        data_t thrust_2;
        data_t thrust_3;
        logic  settled;
    } out_item_t;

    // stage load enables handed to each axis
    typedef struct packed {
        logic take;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/pid_thruster_mixer_unit.sv]
`default_nettype none
// Top level of the four-axis PID controller with thruster mixing.
// Holds gain registers, pipeline control, settle check and output register.
// Depends on pid_mix_pkg, pid_mix_axis and pid_mix_out.
//
//  port group   dir  handshake            content
//  in_*         in   in_valid/in_ready    in_item_t pose error
//  out_*        out  out_valid/out_ready  out_item_t thrusts, settled
//  cfg_*        in   cfg_we               register index and data
//
// Four-stage pipeline: axis state update, gain products, axis term sum,
// mix/round/saturate into the output register. One item per cycle while the
// output is not stalled; the product stage sets the cycle time.
// Reset clears axis state, gains and the valid bits; threshold resets to 41.
// A stalled output holds its item; earlier stages keep filling until full.

module pid_thruster_mixer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pid_mix_pkg::in_item_t                in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pid_mix_pkg::out_item_t               out_item,
    input  logic                                 cfg_we,
    input  logic [pid_mix_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pid_mix_pkg::CFG_W-1:0]        cfg_data
);
    import pid_mix_pkg::*;

    function automatic logic below(input data_t e, input logic [THRESH_W-1:0] t);
        logic [DATA_W-1:0] m;
        m = e[DATA_W-1] ? (~e + DATA_W'(1)) : e;
        return DATA_W'(m) < DATA_W'(t);
    endfunction

    logic [CFG_W-1:0]    gains_reg [NUM_AXES];
    logic [THRESH_W-1:0] thresh_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;
    logic set1_reg;
    logic set2_reg;
    logic set3_reg;
    logic settled_next;

    logic load_out;
    logic en1;
    pipe_ctrl_t ctrl;

    data_t     axis_val [NUM_AXES];
    term_t     term [NUM_AXES];
    out_item_t out_item_next;
    out_item_t out_item_reg;

    assign load_out  = !out_valid_reg || out_ready;
    assign ctrl.en3  = !v3_reg || load_out;
    assign ctrl.en2  = !v2_reg || ctrl.en3;
    assign en1       = !v1_reg || ctrl.en2;
    assign ctrl.take = in_valid && en1;
    assign in_ready  = en1;

    assign settled_next = below(in_item.pos_x, thresh_reg) && below(in_item.pos_y, thresh_reg)
                       && below(in_item.pos_z, thresh_reg) && below(in_item.roll, thresh_reg)
                       && below(in_item.pitch, thresh_reg) && below(in_item.yaw, thresh_reg);

    assign axis_val[AX_SURGE] = in_item.pos_x;
    assign axis_val[AX_HEAVE] = in_item.pos_z;
    assign axis_val[AX_YAW]   = in_item.yaw;
    assign axis_val[AX_PITCH] = in_item.pitch;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        pid_mix_axis u_axis (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .value (axis_val[a]),
            .gains (gains_reg[a]),
            .term  (term[a])
        );
    end

    pid_mix_out u_out (
        .term    (term),
        .settled (set3_reg),
        .item    (out_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gains_reg[i] <= '0;
            end
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SURGE, REG_HEAVE, REG_YAW, REG_PITCH:
                begin
                    gains_reg[cfg_index[AXIS_IDX_W-1:0]] <= cfg_data;
                end
                REG_SETTLE:
                begin
                    thresh_reg <= cfg_data[THRESH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= ctrl.take;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            set1_reg <= settled_next;
        end
        if (ctrl.en2)
        begin
            set2_reg <= set1_reg;
        end
        if (ctrl.en3)
        begin
            set3_reg <= set2_reg;
        end
        if (load_out)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // input only stalls when every stage is full behind a stalled output
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && out_valid_reg && !out_ready))
        else $error("input stalled with a free pipeline slot");

    // an item in the last stage moves on when the output register is empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("item lost between term stage and output");

    // a full pipeline behind a stalled output keeps all its items
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && out_valid_reg && !out_ready)
        |=> (v1_reg && v2_reg && v3_reg && out_valid_reg))
        else $error("item dropped while stalled");

endmodule

`default_nettype wire

[hw/rtl/pid_mix_axis.sv]
`default_nettype none
// One PID axis: previous value and saturating running sum, gain products,
// and the summed axis term in Q.20. Depends on pid_mix_pkg.

module pid_mix_axis (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pid_mix_pkg::pipe_ctrl_t          ctrl,
    input  pid_mix_pkg::data_t               value,
    input  logic [pid_mix_pkg::CFG_W-1:0]    gains,
    output pid_mix_pkg::term_t               term
);
    import pid_mix_pkg::*;

    localparam sum_t SUM_MAX = sum_t'({1'b0, {(SUM_W-1){1'b1}}});
    localparam sum_t SUM_MIN = sum_t'({1'b1, {(SUM_W-1){1'b0}}});

    gain_t offset;
    gain_t kp;
    gain_t kd;
    gain_t ki;

    data_t prev_reg;
    sum_t  acc_reg;
    sum_t  acc_next;
    logic signed [SUM_W:0] acc_wide;
    diff_t diff_next;

    data_t v1_reg;
    diff_t diff1_reg;
    sum_t  sum1_reg;

    logic signed [PV_W-1:0] pv_reg;
    logic signed [PV_W-1:0] pv_next;
    logic signed [PD_W-1:0] pd_reg;
    logic signed [PD_W-1:0] pd_next;
    logic signed [PS_W-1:0] ps_reg;
    logic signed [PS_W-1:0] ps_next;

    term_t term_reg;
    term_t term_next;

    assign offset = gains[15:0];
    assign kp     = gains[31:16];
    assign kd     = gains[47:32];
    assign ki     = gains[63:48];

    always_comb
    begin
        acc_wide  = (SUM_W+1)'(acc_reg) + (SUM_W+1)'(value);
        diff_next = DIFF_W'(value) - DIFF_W'(prev_reg);
        if (acc_wide[SUM_W] != acc_wide[SUM_W-1])
        begin
            acc_next = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            acc_next = acc_wide[SUM_W-1:0];
        end
    end

    assign pv_next = kp * v1_reg;
    assign pd_next = kd * diff1_reg;
    assign ps_next = ki * sum1_reg;

    assign term_next = (term_t'(offset) <<< FRAC_BITS) + term_t'(pv_reg)
                     + term_t'(pd_reg) + term_t'(ps_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            acc_reg  <= '0;
        end
        else if (ctrl.take)
        begin
            prev_reg <= value;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            v1_reg    <= value;
            diff1_reg <= diff_next;
            sum1_reg  <= acc_next;
        end
        if (ctrl.en2)
        begin
            pv_reg <= pv_next;
            pd_reg <= pd_next;
            ps_reg <= ps_next;
        end
        if (ctrl.en3)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire

[hw/rtl/pid_mix_out.sv]
`default_nettype none
// Thruster mixing: combines the four axis terms, rounds Q.20 to Q.12 and
// saturates each command. Depends on pid_mix_pkg.

module pid_mix_out (
    input  pid_mix_pkg::term_t     term [pid_mix_pkg::NUM_AXES],
    input  logic                   settled,
    output pid_mix_pkg::out_item_t item
);
    import pid_mix_pkg::*;

    function automatic data_t round_sat(input mix_t x);
        mix_t r;
        mix_t q;
        mix_t hi;
        mix_t lo;
        r  = x + mix_t'(1 << (RND_SHIFT - 1));
        q  = r >>> RND_SHIFT;
        hi = mix_t'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - mix_t'(1);
        if (q > hi)
        begin
            return hi[DATA_W-1:0];
        end
        else if (q < lo)
        begin
            return lo[DATA_W-1:0];
        end
        return q[DATA_W-1:0];
    endfunction

    mix_t surge;
    mix_t heave;
    mix_t yaw;
    mix_t pitch;

    assign surge = mix_t'(term[AX_SURGE]);
    assign heave = mix_t'(term[AX_HEAVE]);
    assign yaw   = mix_t'(term[AX_YAW]);
    assign pitch = mix_t'(term[AX_PITCH]);

    always_comb
    begin
        item.thrust_0 = round_sat(pitch - heave);
        item.thrust_1 = round_sat(-heave - pitch);
        item.thrust_2 = round_sat(surge - yaw);
        item.thrust_3 = round_sat(surge + yaw);
        item.settled  = settled;
    end

endmodule

`default_nettype wire

[tb/pid_thruster_mixer_unit_tb.sv]
// Self-checking testbench for pid_thruster_mixer_unit: pose error items in, thruster items out.
// A built-in PID/mixer predictor checks every output item field by field.
// Depends on pid_mix_pkg and the pid_thruster_mixer_unit RTL.

module pid_thruster_mixer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pid_mix_pkg::*;

    localparam int    CYCLE_LIMIT = 400000;
    localparam int    DUT_LATENCY = 4;
    localparam data_t DATA_MAX    = data_t'((1 << (DATA_W - 1)) - 1);
    localparam data_t DATA_MIN    = data_t'(1 << (DATA_W - 1));

    typedef enum int {MIX_WIDE, MIX_NEAR, MIX_EDGE} field_mix_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // predictor copy of registers and axis state
    logic [CFG_W-1:0]    gain_reg [NUM_AXES];
    logic [THRESH_W-1:0] settle_thr;
    longint              axis_prev [NUM_AXES];
    longint              axis_sum  [NUM_AXES];

    in_item_t  pose_backlog [$];
    out_item_t thrust_expected [$];
    out_item_t due;

    int items_queued  = 0;
    int results_seen  = 0;
    int settled_seen  = 0;
    int settings_used = 0;
    int errors        = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int ready_hold    = 0;
    int cycle_count   = 0;

    pid_thruster_mixer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_signed(longint x, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    function automatic data_t round_to_thrust(longint q20);
        return data_t'(clamp_signed((q20 + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT,
                                    DATA_W));
    endfunction

    function automatic out_item_t predict_thrust(in_item_t pose);
        longint    err [6];
        longint    val [NUM_AXES];
        longint    term [NUM_AXES];
        longint    offs, kp, kd, ki, diff, acc;
        bit        calm;
        out_item_t res;
        err[0] = pose.pos_x;
        err[1] = pose.pos_y;
        err[2] = pose.pos_z;
        err[3] = pose.roll;
        err[4] = pose.pitch;
        err[5] = pose.yaw;
        calm = 1'b1;
        foreach (err[i])
            if ((err[i] < 0 ? -err[i] : err[i]) >= longint'(settle_thr))
                calm = 1'b0;
        val[AX_SURGE] = err[0];
        val[AX_HEAVE] = err[2];
        val[AX_YAW]   = err[5];
        val[AX_PITCH] = err[4];
        for (int a = 0; a < NUM_AXES; a++)
        begin
            offs = gain_t'(gain_reg[a][15:0]);
            kp   = gain_t'(gain_reg[a][31:16]);
            kd   = gain_t'(gain_reg[a][47:32]);
            ki   = gain_t'(gain_reg[a][63:48]);
            diff = val[a] - axis_prev[a];
            acc  = clamp_signed(axis_sum[a] + val[a], SUM_W);
            axis_sum[a]  = acc;
            axis_prev[a] = val[a];
            term[a] = (offs <<< FRAC_BITS) + kp * val[a] + kd * diff + ki * acc;
        end
        res.thrust_0 = round_to_thrust(-term[AX_HEAVE] + term[AX_PITCH]);
        res.thrust_1 = round_to_thrust(-term[AX_HEAVE] - term[AX_PITCH]);
        res.thrust_2 = round_to_thrust(term[AX_SURGE] - term[AX_YAW]);
        res.thrust_3 = round_to_thrust(term[AX_SURGE] + term[AX_YAW]);
        res.settled  = calm;
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] pack_gains(gain_t offs, gain_t kp, gain_t kd, gain_t ki);
        return {ki, kd, kp, offs};
    endfunction

    function automatic logic [CFG_W-1:0] rand_gains();
        gain_t g [4];
        foreach (g[i])
            g[i] = ($urandom_range(0, 3) == 0) ? gain_t'($urandom)
                                               : gain_t'($urandom_range(0, 1023)) - gain_t'(512);
        return pack_gains(g[0], g[1], g[2], g[3]);
    endfunction

    function automatic data_t rand_field(field_mix_t mix);
        case (mix)
            MIX_WIDE: return data_t'($urandom);
            MIX_NEAR: return data_t'($urandom_range(0, 160)) - data_t'(80);
            default:
                case ($urandom_range(0, 4))
                    0:       return DATA_MAX;
                    1:       return DATA_MIN;
                    2:       return data_t'(0);
                    3:       return data_t'(-1);
                    default: return data_t'(1);
                endcase
        endcase
    endfunction

    function automatic in_item_t rand_pose();
        data_t      f [6];
        int         pick;
        field_mix_t mix;
        pick = $urandom_range(0, 9);
        foreach (f[i])
        begin
            if (pick < 4)
                mix = MIX_WIDE;
            else if (pick < 6)
                mix = MIX_NEAR;
            else if (pick < 8)
                mix = MIX_EDGE;
            else
                mix = field_mix_t'($urandom_range(0, 2));
            f[i] = rand_field(mix);
        end
        return in_item_t'{f[0], f[1], f[2], f[3], f[4], f[5]};
    endfunction

    task automatic queue_pose(in_item_t pose);
        pose_backlog = {pose_backlog, pose};
        items_queued++;
    endtask

    task automatic queue_random(int n);
        repeat (n) queue_pose(rand_pose());
    endtask

    // same level on all four controlled axes, drives the running sums into saturation
    task automatic queue_windup(data_t level, int n);
        in_item_t p;
        repeat (n)
        begin
            p = rand_pose();
            p.pos_x = level;
            p.pos_z = level;
            p.pitch = level;
            p.yaw   = level;
            queue_pose(p);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < NUM_AXES)
            gain_reg[idx[AXIS_IDX_W-1:0]] = value;
        else if (idx == REG_SETTLE)
            settle_thr = value[THRESH_W-1:0];
    endtask

    task automatic apply_setting(logic [CFG_W-1:0] surge_g, logic [CFG_W-1:0] heave_g,
                                 logic [CFG_W-1:0] yaw_g, logic [CFG_W-1:0] pitch_g,
                                 logic [CFG_W-1:0] thr);
        write_reg(REG_SURGE, surge_g);
        write_reg(REG_HEAVE, heave_g);
        write_reg(REG_YAW, yaw_g);
        write_reg(REG_PITCH, pitch_g);
        write_reg(REG_SETTLE, thr);
        settings_used++;
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued)
            @(posedge clk);
    endtask

    // sender: bursts of items separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                thrust_expected = {thrust_expected, predict_thrust(in_item)};
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pose_backlog.size() > 0)
                begin
                    in_item  <= pose_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: alternating ready and stall stretches, plus the result check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_item.settled)
                settled_seen++;
            if (thrust_expected.size() == 0)
            begin
                $error("output item with nothing expected");
                errors++;
            end
            else
            begin
                due = thrust_expected.pop_front();
                if (out_item.thrust_0 !== due.thrust_0)
                begin
                    $error("thrust_0: expected %0d, got %0d", due.thrust_0, out_item.thrust_0);
                    errors++;
                end
                if (out_item.thrust_1 !== due.thrust_1)
                begin
                    $error("thrust_1: expected %0d, got %0d", due.thrust_1, out_item.thrust_1);
                    errors++;
                end
                if (out_item.thrust_2 !== due.thrust_2)
                begin
                    $error("thrust_2: expected %0d, got %0d", due.thrust_2, out_item.thrust_2);
                    errors++;
                end
                if (out_item.thrust_3 !== due.thrust_3)
                begin
                    $error("thrust_3: expected %0d, got %0d", due.thrust_3, out_item.thrust_3);
                    errors++;
                end
                if (out_item.settled !== due.settled)
                begin
                    $error("settled: expected %0d, got %0d", due.settled, out_item.settled);
                    errors++;
                end
            end
        end
        if (ready_hold > 0)
            ready_hold--;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            ready_hold = $urandom_range(1, 6);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold = $urandom_range(1, 24);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pid_thruster_mixer_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            gain_reg[a]  = '0;
            axis_prev[a] = 0;
            axis_sum[a]  = 0;
        end
        settle_thr = THRESH_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset gains: thrusts stay zero, settle boundary at the reset threshold
        queue_pose(in_item_t'{6{data_t'(0)}});
        queue_pose(in_item_t'{6{data_t'(40)}});
        queue_pose(in_item_t'{6{data_t'(-40)}});
        queue_pose(in_item_t'{data_t'(41), data_t'(0), data_t'(0), data_t'(0), data_t'(0),
                              data_t'(0)});
        queue_pose(in_item_t'{data_t'(0), data_t'(-41), data_t'(0), data_t'(0), data_t'(0),
                              data_t'(0)});
        queue_pose(in_item_t'{data_t'(0), data_t'(0), data_t'(0), data_t'(41), data_t'(0),
                              data_t'(0)});
        queue_pose(in_item_t'{data_t'(0), data_t'(0), data_t'(0), data_t'(0), data_t'(0),
                              data_t'(-41)});
        wait_drained();

        // mixed-sign gains; threshold written with junk in the upper bits
        apply_setting(pack_gains(16'sh0010, 16'sh0100, 16'sh0040, 16'sh0002),
                      pack_gains(-16'sh0020, 16'sh0180, -16'sh0040, 16'sh0001),
                      pack_gains(16'sh0000, -16'sh0100, 16'sh0080, -16'sh0003),
                      pack_gains(16'sh0033, 16'sh0200, 16'sh0010, 16'sh0004),
                      64'hFFFF_FFFF_FFF8_0029);
        for (int k = int'(REG_SETTLE) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(k[CFG_IDX_W-1:0], '1);
        queue_pose(in_item_t'{6{DATA_MAX}});
        queue_pose(in_item_t'{6{DATA_MAX}});
        queue_pose(in_item_t'{6{DATA_MIN}});
        queue_pose(in_item_t'{6{DATA_MAX}});
        queue_pose(in_item_t'{6{data_t'(0)}});
        queue_pose(in_item_t'{6{data_t'(20'h55555)}});
        queue_pose(in_item_t'{6{data_t'(20'hAAAAA)}});
        queue_pose(in_item_t'{6{data_t'(-1)}});
        queue_pose(in_item_t'{6{data_t'(1)}});
        queue_pose(in_item_t'{DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX});
        queue_random(60);
        wait_drained();

        // largest gains, zero threshold, positive windup
        apply_setting({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, '0);
        queue_windup(DATA_MAX, 280);
        queue_windup(DATA_MIN, 20);
        queue_random(20);
        wait_drained();

        // most negative gains, largest threshold, negative windup
        apply_setting({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                      64'(19'h7FFFF));
        queue_windup(DATA_MIN, 300);
        queue_windup(DATA_MAX, 20);
        wait_drained();

        // all-ones gains
        apply_setting('1, '1, '1, '1, 64'(THRESH_RESET));
        queue_random(100);
        wait_drained();

        repeat (6)
        begin
            apply_setting(rand_gains(), rand_gains(), rand_gains(), rand_gains(),
                          {$urandom, $urandom} & ~64'(19'h7FFFF) |
                          (($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 19'h7FFFF))
                                                       : 64'($urandom_range(0, 120))));
            queue_random(100);
            wait_drained();
        end

        repeat (2 * DUT_LATENCY) @(posedge clk);
        if (thrust_expected.size() != 0)
        begin
            $error("%0d expected output items never arrived", thrust_expected.size());
            errors++;
        end
        $display("%0d pose items checked over %0d register settings, %0d reported settled;",
                 results_seen, settings_used, settled_seen);
        $display("windup into both sum limits, thrust saturation and unused register writes run");
        if (errors == 0)
            $display("pid_thruster_mixer_unit_tb passed");
        else
            $display("pid_thruster_mixer_unit_tb failed");
        $finish;
    end

endmodule

[pid_thruster_mixer_unit.f]
hw/rtl/pid_mix_pkg.sv
hw/rtl/pid_mix_axis.sv
hw/rtl/pid_mix_out.sv
hw/rtl/pid_thruster_mixer_unit.sv
tb/pid_thruster_mixer_unit_tb.sv
